// ===== rtl/yuv_pixel_color_adjust_assert.svh =====
// ---------------------------------------------------------------------------
// yuv_pixel_color_adjust assertion macros
// shared property shapes for the color adjust checks
// ---------------------------------------------------------------------------
`ifndef YUV_PIXEL_COLOR_ADJUST_ASSERT_SVH
`define YUV_PIXEL_COLOR_ADJUST_ASSERT_SVH

// same-cycle implication, idle while reset is low
`define YPCA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("ypca check failed");

// next-cycle implication, idle while reset is low
`define YPCA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("ypca check failed");

// next-cycle implication, also checked through reset
`define YPCA_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ypca check failed");

`endif

// ===== rtl/ypca_pkg.sv =====
// ---------------------------------------------------------------------------
// ypca_pkg
// widths, register indexes and helpers for the yuv pixel color adjust block
// ---------------------------------------------------------------------------
package ypca_pkg;

  localparam int PIX_W    = 8;
  localparam int DATA_W   = 3 * PIX_W;
  localparam int GAIN_W   = 8;
  localparam int OFS_W    = 11;
  localparam int MUL_W    = 8;
  localparam int CFG_W    = 11;
  localparam int IDX_W    = 3;

  localparam int YPROD_W  = 16;  // unsigned gain * y
  localparam int CPROD_W  = 16;  // signed chroma products
  localparam int CSUM_W   = 17;
  localparam int Y_SHIFT  = 6;   // luma gain in 1/64
  localparam int UV_SHIFT = 5;   // chroma factors in 1/32
  localparam int YQ_W     = YPROD_W - Y_SHIFT;
  localparam int CQ_W     = CSUM_W - UV_SHIFT;
  localparam int RES_W    = 13;

  localparam logic [IDX_W-1:0] REG_Y_GAIN   = 3'd0;
  localparam logic [IDX_W-1:0] REG_Y_OFFSET = 3'd1;
  localparam logic [IDX_W-1:0] REG_MUL_UV   = 3'd2;
  localparam logic [IDX_W-1:0] REG_MUL_VU   = 3'd3;
  localparam logic [IDX_W-1:0] REG_UV_ADD   = 3'd4;

  localparam logic [GAIN_W-1:0] Y_GAIN_RST  = 8'd64;
  localparam logic [MUL_W-1:0]  MUL_UV_RST  = 8'd32;

  localparam logic signed [RES_W-1:0] PIX_MAX = 13'sd255;

  // clip a signed intermediate to the pixel range
  function automatic logic [PIX_W-1:0] clip8(input logic signed [RES_W-1:0] x);
    logic [PIX_W-1:0] r;
    if (x < 0) begin
      r = '0;
    end else if (x > PIX_MAX) begin
      r = PIX_MAX[PIX_W-1:0];
    end else begin
      r = x[PIX_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/yuv_pixel_color_adjust.sv =====
// ---------------------------------------------------------------------------
// yuv_pixel_color_adjust
// per-pixel luma gain/offset and chroma hue/saturation mix with clipping
// ---------------------------------------------------------------------------
// one yuv pixel per item on the in_ stream, one adjusted pixel per item on
// the out_ stream, tlast passed along with its pixel.
// y' = gain*y/64 + y_offset, u' = (u*mul_uv + v*mul_vu)/32 + uv_add,
// v' = (v*mul_uv + u*mul_vu)/32 + uv_add, divisions truncate toward zero,
// all results clipped to 0..255.
// pipeline: stage 1 multiplies, stage 2 sums and scales, stage 3 adds the
// offsets, clips and holds the output item. An accepted item passes the
// stage 1, 2 and 3 registers before out_tvalid offers it; one item per
// cycle is accepted while the output is taken every cycle.
// when out_tready is low the stages fill up one by one; in_tready drops
// only once all three stages hold an item, nothing is dropped or repeated.
// the user writes registers via cfg_we/cfg_index/cfg_wdata while the pipe
// is empty, not enforced by the block; indexes beyond the list are ignored.
// reset empties the pipeline and loads the identity settings
// (gain 64, mul_uv 32, offsets and cross factor 0).
// ---------------------------------------------------------------------------
module yuv_pixel_color_adjust (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [ypca_pkg::DATA_W-1:0]  in_tdata,   // y_in, u_in, v_in
  input  logic                         in_tlast,   // last_in
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [ypca_pkg::DATA_W-1:0]  out_tdata,  // y_out, u_out, v_out
  output logic                         out_tlast,  // last_out
  input  logic                         cfg_we,
  input  logic [ypca_pkg::IDX_W-1:0]   cfg_index,
  input  logic [ypca_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int PW = ypca_pkg::PIX_W;

  // configuration registers
  logic        [ypca_pkg::GAIN_W-1:0] y_gain_r;
  logic signed [ypca_pkg::OFS_W-1:0]  y_offset_r;
  logic signed [ypca_pkg::MUL_W-1:0]  mul_uv_r;
  logic signed [ypca_pkg::MUL_W-1:0]  mul_vu_r;
  logic signed [ypca_pkg::OFS_W-1:0]  uv_add_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_gain_r   <= ypca_pkg::Y_GAIN_RST;
      y_offset_r <= '0;
      mul_uv_r   <= ypca_pkg::MUL_UV_RST;
      mul_vu_r   <= '0;
      uv_add_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ypca_pkg::REG_Y_GAIN:   y_gain_r   <= cfg_wdata[ypca_pkg::GAIN_W-1:0];
        ypca_pkg::REG_Y_OFFSET: y_offset_r <= cfg_wdata[ypca_pkg::OFS_W-1:0];
        ypca_pkg::REG_MUL_UV:   mul_uv_r   <= cfg_wdata[ypca_pkg::MUL_W-1:0];
        ypca_pkg::REG_MUL_VU:   mul_vu_r   <= cfg_wdata[ypca_pkg::MUL_W-1:0];
        ypca_pkg::REG_UV_ADD:   uv_add_r   <= cfg_wdata[ypca_pkg::OFS_W-1:0];
        default: ;
      endcase
    end
  end

  // stage handshake
  logic vld1_r, vld2_r, vld3_r;
  logic rdy1, rdy2, rdy3;

  assign rdy3      = !vld3_r || out_tready;
  assign rdy2      = !vld2_r || rdy3;
  assign rdy1      = !vld1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      if (rdy1) vld1_r <= in_tvalid;
      if (rdy2) vld2_r <= vld1_r;
      if (rdy3) vld3_r <= vld2_r;
    end
  end

  // stage 1: products
  logic signed [PW:0] u_s, v_s;
  logic [ypca_pkg::YPROD_W-1:0]        yp_nxt, yp_r;
  logic signed [ypca_pkg::CPROD_W-1:0] uuv_nxt, vvu_nxt, vuv_nxt, uvu_nxt;
  logic signed [ypca_pkg::CPROD_W-1:0] uuv_r, vvu_r, vuv_r, uvu_r;
  logic last1_r;

  assign u_s     = {1'b0, in_tdata[2*PW-1:PW]};
  assign v_s     = {1'b0, in_tdata[3*PW-1:2*PW]};
  assign yp_nxt  = y_gain_r * in_tdata[PW-1:0];
  assign uuv_nxt = u_s * mul_uv_r;
  assign vvu_nxt = v_s * mul_vu_r;
  assign vuv_nxt = v_s * mul_uv_r;
  assign uvu_nxt = u_s * mul_vu_r;

  always_ff @(posedge clk) begin
    if (rdy1 && in_tvalid) begin
      yp_r    <= yp_nxt;
      uuv_r   <= uuv_nxt;
      vvu_r   <= vvu_nxt;
      vuv_r   <= vuv_nxt;
      uvu_r   <= uvu_nxt;
      last1_r <= in_tlast;
    end
  end

  // stage 2: sums, biased so the shift truncates toward zero
  logic signed [ypca_pkg::CSUM_W-1:0] su, sv, bu, bv;
  logic [ypca_pkg::YQ_W-1:0]          yq_nxt, yq_r;
  logic signed [ypca_pkg::CQ_W-1:0]   uq_nxt, vq_nxt, uq_r, vq_r;
  logic last2_r;

  localparam logic signed [ypca_pkg::CSUM_W-1:0] UV_BIAS =
    ypca_pkg::CSUM_W'((1 << ypca_pkg::UV_SHIFT) - 1);

  assign su     = ypca_pkg::CSUM_W'(uuv_r) + ypca_pkg::CSUM_W'(vvu_r);
  assign sv     = ypca_pkg::CSUM_W'(vuv_r) + ypca_pkg::CSUM_W'(uvu_r);
  assign bu     = su[ypca_pkg::CSUM_W-1] ? su + UV_BIAS : su;
  assign bv     = sv[ypca_pkg::CSUM_W-1] ? sv + UV_BIAS : sv;
  assign uq_nxt = bu[ypca_pkg::CSUM_W-1:ypca_pkg::UV_SHIFT];
  assign vq_nxt = bv[ypca_pkg::CSUM_W-1:ypca_pkg::UV_SHIFT];
  assign yq_nxt = yp_r[ypca_pkg::YPROD_W-1:ypca_pkg::Y_SHIFT];

  always_ff @(posedge clk) begin
    if (rdy2 && vld1_r) begin
      yq_r    <= yq_nxt;
      uq_r    <= uq_nxt;
      vq_r    <= vq_nxt;
      last2_r <= last1_r;
    end
  end

  // stage 3: offsets and clip
  logic signed [ypca_pkg::RES_W-1:0] ny, nu, nv;
  logic [ypca_pkg::DATA_W-1:0] data3_nxt, data3_r;
  logic last3_r;

  assign ny = ypca_pkg::RES_W'($signed({1'b0, yq_r})) + ypca_pkg::RES_W'(y_offset_r);
  assign nu = ypca_pkg::RES_W'(uq_r) + ypca_pkg::RES_W'(uv_add_r);
  assign nv = ypca_pkg::RES_W'(vq_r) + ypca_pkg::RES_W'(uv_add_r);
  assign data3_nxt = {ypca_pkg::clip8(nv), ypca_pkg::clip8(nu), ypca_pkg::clip8(ny)};

  always_ff @(posedge clk) begin
    if (rdy3 && vld2_r) begin
      data3_r <= data3_nxt;
      last3_r <= last2_r;
    end
  end

  assign out_tvalid = vld3_r;
  assign out_tdata  = data3_r;
  assign out_tlast  = last3_r;

endmodule

// ===== rtl/ypca_checker.sv =====
// ---------------------------------------------------------------------------
// ypca_checker
// port-level checks for yuv_pixel_color_adjust, bound to the top level
// ---------------------------------------------------------------------------
`include "yuv_pixel_color_adjust_assert.svh"

module ypca_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [ypca_pkg::DATA_W-1:0]  out_tdata,  // y_out, u_out, v_out
  input logic                         out_tlast   // last_out
);

  logic out_stall;
  assign out_stall = out_tvalid && !out_tready;

  // a stalled output item stays offered and unchanged
  `YPCA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_tvalid)
  `YPCA_ASSERT_NEXT(a_out_stable, clk, rst_n, out_stall,
                    $stable(out_tdata) && $stable(out_tlast))

  // reset empties the pipe
  `YPCA_ASSERT_NEXT_ALWAYS(a_rst_empty, clk, !rst_n, !out_tvalid)

  // an empty output stage means the pipe can take an item
  `YPCA_ASSERT_NOW(a_empty_ready, clk, rst_n, !out_tvalid, in_tready)

endmodule

bind yuv_pixel_color_adjust ypca_checker u_ypca_checker (.*);

// ===== tb/sv/ypca_checker.sv =====
// ----------------------------------------------------------------------------
// ypca_scoreboard
// watches the pixel streams and the register port of the color adjust block,
// predicts every adjusted pixel from its own copy of the registers and
// compares each output item with the oldest predicted pixel
// ----------------------------------------------------------------------------
module ypca_scoreboard (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [ypca_pkg::DATA_W-1:0] in_tdata,   // y_in, u_in, v_in
  input  logic                        in_tlast,   // last_in
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [ypca_pkg::DATA_W-1:0] out_tdata,  // y_out, u_out, v_out
  input  logic                        out_tlast,  // last_out
  input  logic                        cfg_we,
  input  logic [ypca_pkg::IDX_W-1:0]  cfg_index,
  input  logic [ypca_pkg::CFG_W-1:0]  cfg_wdata,
  output int                          fail_count,
  output int                          pending,
  output int                          checked_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PW         = ypca_pkg::PIX_W;
  localparam int DW         = ypca_pkg::DATA_W;
  localparam int LUMA_DIV   = 64;
  localparam int CHROMA_DIV = 32;
  localparam int PIX_TOP    = 255;

  typedef struct packed {
    logic [PW-1:0] y;
    logic [PW-1:0] u;
    logic [PW-1:0] v;
    logic          last;
  } pixel_t;

  logic [ypca_pkg::GAIN_W-1:0]       gain_q;
  logic signed [ypca_pkg::OFS_W-1:0] yofs_q;
  logic signed [ypca_pkg::MUL_W-1:0] muv_q;
  logic signed [ypca_pkg::MUL_W-1:0] mvu_q;
  logic signed [ypca_pkg::OFS_W-1:0] uvadd_q;

  pixel_t expected_pixels[$];

  function automatic logic [PW-1:0] clamp_pixel(input int x);
    if (x < 0) return '0;
    if (x > PIX_TOP) return PW'(PIX_TOP);
    return PW'(x);
  endfunction

  function automatic pixel_t adjust_pixel(input logic [DW-1:0] data, input logic last);
    int     y, u, v;
    pixel_t p;
    y = int'(data[PW-1:0]);
    u = int'(data[2*PW-1:PW]);
    v = int'(data[DW-1:2*PW]);
    // int division truncates toward zero
    p.y    = clamp_pixel((int'(gain_q) * y) / LUMA_DIV + int'(yofs_q));
    p.u    = clamp_pixel((u * int'(muv_q) + v * int'(mvu_q)) / CHROMA_DIV + int'(uvadd_q));
    p.v    = clamp_pixel((v * int'(muv_q) + u * int'(mvu_q)) / CHROMA_DIV + int'(uvadd_q));
    p.last = last;
    return p;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    pixel_t want;
    if (!rst_n) begin
      gain_q  = ypca_pkg::Y_GAIN_RST;
      yofs_q  = '0;
      muv_q   = ypca_pkg::MUL_UV_RST;
      mvu_q   = '0;
      uvadd_q = '0;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ypca_pkg::REG_Y_GAIN:   gain_q  = cfg_wdata[ypca_pkg::GAIN_W-1:0];
          ypca_pkg::REG_Y_OFFSET: yofs_q  = cfg_wdata[ypca_pkg::OFS_W-1:0];
          ypca_pkg::REG_MUL_UV:   muv_q   = cfg_wdata[ypca_pkg::MUL_W-1:0];
          ypca_pkg::REG_MUL_VU:   mvu_q   = cfg_wdata[ypca_pkg::MUL_W-1:0];
          ypca_pkg::REG_UV_ADD:   uvadd_q = cfg_wdata[ypca_pkg::OFS_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        expected_pixels.push_back(adjust_pixel(in_tdata, in_tlast));
      end
      if (out_tvalid && out_tready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected output item: no pixel waiting");
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("y_out", want.y, out_tdata[PW-1:0]);
          check_field("u_out", want.u, out_tdata[2*PW-1:PW]);
          check_field("v_out", want.v, out_tdata[DW-1:2*PW]);
          check_field("last_out", want.last, out_tlast);
          checked_count++;
        end
      end
    end
    pending = expected_pixels.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the yuv pixel color adjust block: directed pixels
// at the range extremes and truncation corners, then random frames under
// changing register settings with random gaps and output stalls
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PW = ypca_pkg::PIX_W;
  localparam int DW = ypca_pkg::DATA_W;
  localparam int IW = ypca_pkg::IDX_W;
  localparam int CW = ypca_pkg::CFG_W;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int TAIL_CYCLES  = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASES       = 8;
  localparam int PHASE_PIXELS = 162;

  localparam int MODE_NATURAL = 0;
  localparam int MODE_WIDE    = 1;
  localparam int MODE_CORNERS = 2;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [DW-1:0] in_tdata = '0;    // y_in, u_in, v_in
  logic          in_tlast = 1'b0;  // last_in
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [DW-1:0] out_tdata;        // y_out, u_out, v_out
  logic          out_tlast;        // last_out
  logic          cfg_we = 1'b0;
  logic [IW-1:0] cfg_index = '0;
  logic [CW-1:0] cfg_wdata = '0;

  int fail_count;
  int pending;
  int checked_count;

  int  cycle_count = 0;
  int  pixels_sent = 0;
  int  frames_sent = 0;
  int  settings_count = 0;
  int  held_cycles = 0;
  bit  calm = 1'b0;
  bit  rush = 1'b0;
  bit  hold_req = 1'b0;

  yuv_pixel_color_adjust u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  ypca_scoreboard u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // output side: per-item stall, one long hold-off on request
  initial begin
    int   stall;
    logic got;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        stall = HOLD_CYCLES;
        hold_req = 1'b0;
        held_cycles = HOLD_CYCLES;
      end else begin
        stall = calm ? 0 : $urandom_range(0, 19);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do begin
        @(negedge clk);
        got = out_tvalid;
        @(posedge clk);
      end while (!got);
    end
  end

  // only the low 8 bits matter for the 8-bit registers, junk goes above
  function automatic logic [CW-1:0] with_junk(input int value);
    return CW'((value & 32'hFF) | ($urandom_range(0, 7) << 8));
  endfunction

  task automatic program_regs(input int gain, input int yoff, input int muv, input int mvu,
                              input int add);
    cfg_we    <= 1'b1;
    cfg_index <= ypca_pkg::REG_Y_GAIN;
    cfg_wdata <= with_junk(gain);
    @(posedge clk);
    cfg_index <= ypca_pkg::REG_Y_OFFSET;
    cfg_wdata <= CW'(yoff);
    @(posedge clk);
    cfg_index <= ypca_pkg::REG_MUL_UV;
    cfg_wdata <= with_junk(muv);
    @(posedge clk);
    cfg_index <= ypca_pkg::REG_MUL_VU;
    cfg_wdata <= with_junk(mvu);
    @(posedge clk);
    cfg_index <= ypca_pkg::REG_UV_ADD;
    cfg_wdata <= CW'(add);
    @(posedge clk);
    // index past the register list, must be dropped
    cfg_index <= ypca_pkg::REG_UV_ADD + IW'($urandom_range(1, 3));
    cfg_wdata <= CW'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  task automatic random_settings(input int mode);
    case (mode)
      MODE_NATURAL: begin
        program_regs($urandom_range(32, 128), int'($urandom_range(0, 128)) - 64,
                     $urandom_range(0, 64), int'($urandom_range(0, 64)) - 32,
                     int'($urandom_range(0, 256)) - 64);
      end
      MODE_WIDE: begin
        program_regs($urandom_range(0, 255), int'($urandom_range(0, 2047)) - 1024,
                     int'($urandom_range(0, 255)) - 128, int'($urandom_range(0, 255)) - 128,
                     int'($urandom_range(0, 2047)) - 1024);
      end
      default: begin
        program_regs($urandom_range(0, 1) ? 255 : 0, $urandom_range(0, 1) ? 1023 : -1024,
                     $urandom_range(0, 1) ? 127 : -128, $urandom_range(0, 1) ? 127 : -128,
                     $urandom_range(0, 1) ? 1023 : -1024);
      end
    endcase
  endtask

  task automatic send_pixel(input logic [PW-1:0] y, input logic [PW-1:0] u,
                            input logic [PW-1:0] v, input logic last);
    int   gap;
    logic got;
    gap = (calm || rush) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {v, u, y};
    in_tlast  <= last;
    do begin
      @(negedge clk);
      got = in_tready;
      @(posedge clk);
    end while (!got);
    pixels_sent++;
  endtask

  // block must be empty before the registers change
  task automatic drain;
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic logic [PW-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PW'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int  len;
    int  phase_pixels;
    bit  last;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity after reset
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd1, 8'd254, 8'd128, 1'b0);
    drain;

    // everything at the top, sums clip high
    program_regs(255, 1023, 127, 127, 1023);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    drain;

    // everything at the bottom, sums clip low
    program_regs(0, -1024, -128, -128, -1024);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    drain;

    // small negative sums must truncate toward zero, not floor
    program_regs(1, 5, -1, 0, 10);
    send_pixel(8'd63, 8'd31, 8'd33, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd0, 1'b1);
    send_pixel(8'd64, 8'd32, 8'd95, 1'b0);
    drain;

    // hue rotation with opposite cross factor
    program_regs(128, -3, 16, -16, 128);
    send_pixel(8'd200, 8'd10, 8'd250, 1'b0);
    send_pixel(8'd127, 8'd250, 8'd10, 1'b1);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain;
      if (phase % 3 == 2) begin
        random_settings(MODE_CORNERS);
      end else begin
        random_settings((phase == 0) ? MODE_NATURAL : $urandom_range(MODE_NATURAL, MODE_WIDE));
      end
      if (phase == 3) begin
        // long output hold-off while the input keeps pushing
        hold_req = 1'b1;
        rush = 1'b1;
      end
      phase_pixels = 0;
      while (phase_pixels < PHASE_PIXELS) begin
        len = $urandom_range(1, 40);
        calm = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++) begin
          last = (i == len - 1) ^ ($urandom_range(0, 15) == 0);
          send_pixel(pick_sample(), pick_sample(), pick_sample(), last);
        end
        frames_sent++;
        phase_pixels += len;
        if (held_cycles > 0) rush = 1'b0;
      end
    end
    calm = 1'b0;
    drain;

    $display("tb: %0d pixels in %0d frames under %0d register settings, %0d outputs checked",
             pixels_sent, frames_sent, settings_count, checked_count);
    $display("tb: output held off %0d cycles once to back up the input", held_cycles);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ypca_pkg.sv
rtl/yuv_pixel_color_adjust.sv
rtl/ypca_checker.sv
tb/sv/ypca_checker.sv
tb/sv/tb.sv
